// File: design/bsr_pkg.sv
// Package for the bisection square root block.
// Holds the shared control struct and fixed field widths; no dependencies.
`default_nettype none
package bsr_pkg;

	// Width of the step counter and the iteration cap.
	localparam int STEP_W = 7;
	// Largest cap that the iteration limit saturates to.
	localparam logic [STEP_W-1:0] MAX_CAP = 7'd64;
	// Width of the tolerance register.
	localparam int TOL_W = 32;

	// Status that travels with each item down the pipeline.
	typedef struct packed {
		logic valid;
		logic done;
		logic hit;
	} bsr_ctl_t;

endpackage
`default_nettype wire

// File: design/bisection_square_root_top.sv
// Bisection square root, default input Q16.16, with NB = (INT_BITS+1)/2 integer root bits;
// one item accepted per cycle when not stalled.
// The integer part comes from one root digit per stage, then one squaring stage and one
// compare stage per bisection step; once the interval is one LSB wide the midpoint stops
// moving, so a search still open after FRAC_BITS steps finishes at the cap.
// Reset clears all valid bits and loads tolerance 655 and max_iterations 32.
`default_nettype none
module bisection_square_root_top import bsr_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int INT_BITS = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [2:0]                             paddr,
	input  wire logic [31:0]                            pwdata,
	output logic      [31:0]                            prdata,
	output logic                                        pready,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [INT_BITS+FRAC_BITS-1:0]          radicand,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [(INT_BITS+1)/2+FRAC_BITS-1:0]         root,
	output logic [STEP_W-1:0]                           step_count,
	output logic                                        limit_hit
);

	localparam int NB  = (INT_BITS + 1) / 2;
	localparam int VW  = INT_BITS + FRAC_BITS;
	localparam int RW  = NB + FRAC_BITS;
	localparam int RMW = NB + 3;
	localparam int DW  = (2*RW > TOL_W + FRAC_BITS) ? 2*RW : TOL_W + FRAC_BITS;
	localparam int NS  = FRAC_BITS + 1;

	localparam logic [2:0] ADDR_TOL  = 3'd0;
	localparam logic [2:0] ADDR_ITER = 3'd4;

	logic [TOL_W-1:0]  tolerance_q;
	logic [STEP_W-1:0] max_iterations_q;
	logic [STEP_W-1:0] cap;
	logic              advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q      <= 32'd655;
			max_iterations_q <= 7'd32;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				ADDR_TOL:  tolerance_q      <= pwdata;
				ADDR_ITER: max_iterations_q <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pready = 1'b1;
		unique case (paddr)
			ADDR_TOL:  prdata = tolerance_q;
			ADDR_ITER: prdata = 32'(max_iterations_q);
			default:   prdata = '0;
		endcase
	end

	assign cap = (max_iterations_q > MAX_CAP) ? MAX_CAP : max_iterations_q;

	// The whole pipeline moves together unless a finished item waits at the output.
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	// Integer part: one digit of the root per stage.
	logic              sv_s  [NB+1];
	logic [VW-1:0]     sr_s  [NB+1];
	logic [RMW-1:0]    rem_s [NB+1];
	logic [NB-1:0]     rt_s  [NB+1];
	logic [2*NB-1:0]   vint;

	assign sv_s[0]  = in_valid;
	assign sr_s[0]  = radicand;
	assign rem_s[0] = '0;
	assign rt_s[0]  = '0;

	for (genvar j = 0; j < NB; j++) begin : g_isqrt
		logic [2*NB-1:0] vi;
		logic [RMW-1:0]  rem_sh;
		logic [RMW-1:0]  trial;
		assign vi     = (2*NB)'(sr_s[j] >> FRAC_BITS);
		assign rem_sh = {rem_s[j][RMW-3:0], vi[2*(NB-1-j)+1 -: 2]};
		assign trial  = {1'b0, rt_s[j], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[j+1] <= 1'b0;
			end else if (advance) begin
				sv_s[j+1] <= sv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				sr_s[j+1] <= sr_s[j];
				if (rem_sh >= trial) begin
					rem_s[j+1] <= rem_sh - trial;
					rt_s[j+1]  <= {rt_s[j][NB-2:0], 1'b1};
				end else begin
					rem_s[j+1] <= rem_sh;
					rt_s[j+1]  <= {rt_s[j][NB-2:0], 1'b0};
				end
			end
		end
	end
	assign vint = '0;

	// Integer candidate: square it.
	logic              iv_s1;
	logic [VW-1:0]     ir_s1;
	logic [RW-1:0]     ia_s1;
	logic [2*RW-1:0]   isq_s1;
	logic [RW-1:0]     a0;

	assign a0 = {rt_s[NB], {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_s1 <= 1'b0;
		end else if (advance) begin
			iv_s1 <= sv_s[NB];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ir_s1  <= sr_s[NB] | VW'(vint);
			ia_s1  <= a0;
			isq_s1 <= a0 * a0;
		end
	end

	// Integer candidate: accept it when within tolerance, else open [n, n+1].
	logic [DW-1:0]     isq_ext;
	logic [DW-1:0]     itarget;
	logic [DW-1:0]     itol;
	logic [DW-1:0]     idiff;
	logic [RW:0]       ib;

	always_comb begin
		isq_ext = DW'(isq_s1);
		itarget = DW'(ir_s1) << FRAC_BITS;
		itol    = DW'(tolerance_q) << FRAC_BITS;
		idiff   = (isq_ext >= itarget) ? (isq_ext - itarget) : (itarget - isq_ext);
		ib      = (RW+1)'(ia_s1) + ((RW+1)'(1) << FRAC_BITS);
	end

	bsr_ctl_t          ctl_c [NS+1];
	logic [VW-1:0]     v_c   [NS+1];
	logic [RW-1:0]     a_c   [NS+1];
	logic [RW:0]       b_c   [NS+1];
	logic [RW-1:0]     x_c   [NS+1];
	logic [STEP_W-1:0] st_c  [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_c[0] <= '0;
		end else if (advance) begin
			ctl_c[0].valid <= iv_s1;
			ctl_c[0].done  <= idiff <= itol;
			ctl_c[0].hit   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			v_c[0]  <= ir_s1;
			a_c[0]  <= ia_s1;
			b_c[0]  <= ib;
			x_c[0]  <= (idiff <= itol) ? ia_s1 : ia_s1 + (RW'(1) << (FRAC_BITS - 1));
			st_c[0] <= '0;
		end
	end

	// Bisection steps, one module per step count.
	for (genvar k = 0; k < NS; k++) begin : g_step
		bsr_step #(
			.FRAC_BITS (FRAC_BITS),
			.VW        (VW),
			.RW        (RW),
			.DW        (DW),
			.K         (k)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.ctl_in    (ctl_c[k]),
			.v_in      (v_c[k]),
			.a_in      (a_c[k]),
			.b_in      (b_c[k]),
			.x_in      (x_c[k]),
			.steps_in  (st_c[k]),
			.tol       (tolerance_q),
			.cap       (cap),
			.ctl_out   (ctl_c[k+1]),
			.v_out     (v_c[k+1]),
			.a_out     (a_c[k+1]),
			.b_out     (b_c[k+1]),
			.x_out     (x_c[k+1]),
			.steps_out (st_c[k+1])
		);
	end

	// Output register; a search still open here runs to the cap with a frozen midpoint.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= ctl_c[NS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			root       <= x_c[NS];
			step_count <= ctl_c[NS].done ? st_c[NS] : cap;
			limit_hit  <= ctl_c[NS].done ? ctl_c[NS].hit : 1'b1;
		end
	end

	// A result never reports more steps than the saturated cap allows.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> step_count <= MAX_CAP)
		else $error("step count above cap");

	// A result that met the tolerance did so within the bisection stages.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !limit_hit) |-> step_count <= STEP_W'(NS))
		else $error("tolerance met beyond last stage");

	// Input is held off exactly when a finished item waits at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall out of step with output");

endmodule
`default_nettype wire

// File: design/bsr_step.sv
// One bisection step: a squaring stage and a compare-and-update stage.
// Depends on bsr_pkg for the control struct and the step counter width.
`default_nettype none
module bsr_step import bsr_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int VW = 32,
	parameter int RW = 24,
	parameter int DW = 48,
	parameter int K = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire bsr_ctl_t            ctl_in,
	input  wire logic [VW-1:0]       v_in,
	input  wire logic [RW-1:0]       a_in,
	input  wire logic [RW:0]         b_in,
	input  wire logic [RW-1:0]       x_in,
	input  wire logic [STEP_W-1:0]   steps_in,
	input  wire logic [TOL_W-1:0]    tol,
	input  wire logic [STEP_W-1:0]   cap,
	output bsr_ctl_t                 ctl_out,
	output logic      [VW-1:0]       v_out,
	output logic      [RW-1:0]       a_out,
	output logic      [RW:0]         b_out,
	output logic      [RW-1:0]       x_out,
	output logic      [STEP_W-1:0]   steps_out
);

	bsr_ctl_t              ctl_s1;
	logic [VW-1:0]         v_s1;
	logic [RW-1:0]         a_s1;
	logic [RW:0]           b_s1;
	logic [RW-1:0]         x_s1;
	logic [STEP_W-1:0]     steps_s1;
	logic [2*RW-1:0]       sq_s1;

	logic [DW-1:0]         sq_ext;
	logic [DW-1:0]         target;
	logic [DW-1:0]         tol_ext;
	logic [DW-1:0]         diff;
	logic                  below;
	logic [RW-1:0]         a_nxt;
	logic [RW:0]           b_nxt;
	logic [RW+1:0]         sum;

	// Stage one: square the midpoint.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			v_s1     <= v_in;
			a_s1     <= a_in;
			b_s1     <= b_in;
			x_s1     <= x_in;
			steps_s1 <= steps_in;
			sq_s1    <= x_in * x_in;
		end
	end

	// Distance of the square from the radicand, both at twice the fraction bits.
	always_comb begin
		sq_ext  = DW'(sq_s1);
		target  = DW'(v_s1) << FRAC_BITS;
		tol_ext = DW'(tol) << FRAC_BITS;
		below   = sq_ext < target;
		diff    = below ? (target - sq_ext) : (sq_ext - target);
		a_nxt   = below ? x_s1 : a_s1;
		b_nxt   = below ? b_s1 : (RW+1)'(x_s1);
		sum     = (RW+2)'(a_nxt) + (RW+2)'(b_nxt);
	end

	// Stage two: a done item passes; else tolerance test, then cap test, then move one end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (advance) begin
			ctl_out.valid <= ctl_s1.valid;
			if (ctl_s1.done) begin
				ctl_out.done <= 1'b1;
				ctl_out.hit  <= ctl_s1.hit;
			end else if (diff < tol_ext) begin
				ctl_out.done <= 1'b1;
				ctl_out.hit  <= 1'b0;
			end else if (STEP_W'(K) >= cap) begin
				ctl_out.done <= 1'b1;
				ctl_out.hit  <= 1'b1;
			end else begin
				ctl_out.done <= 1'b0;
				ctl_out.hit  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			v_out <= v_s1;
			if (ctl_s1.done || diff < tol_ext || STEP_W'(K) >= cap) begin
				a_out     <= a_s1;
				b_out     <= b_s1;
				x_out     <= x_s1;
				steps_out <= ctl_s1.done ? steps_s1 : STEP_W'(K);
			end else begin
				a_out     <= a_nxt;
				b_out     <= b_nxt;
				x_out     <= sum[RW:1];
				steps_out <= STEP_W'(K + 1);
			end
		end
	end

endmodule
`default_nettype wire
